// ----- hdl/atr_pkg.sv -----
package atr_pkg;

	localparam int unsigned PRICE_W      = 32;
	localparam int unsigned PERIOD_W     = 10;
	localparam int unsigned SUM_W        = 42;
	localparam int unsigned AVG_W        = 48;
	localparam int unsigned FRAC_X       = 16;
	localparam int unsigned PROD_W       = AVG_W + PERIOD_W;
	localparam int unsigned NUM_W        = PROD_W + 1;
	localparam int unsigned CNT_W        = $clog2(NUM_W);
	localparam int unsigned DATA_W       = 32;
	localparam int unsigned ADDR_W       = 3;
	localparam int unsigned MAX_PERIOD   = 1023;

	localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(14);
	localparam logic [ADDR_W-1:0]   ADDR_PERIOD  = ADDR_W'(0);

	// Controller to datapath
	typedef struct packed {
		logic capture;
		logic range;
		logic update;
		logic load_sum;
		logic load_acc;
		logic div_step;
		logic out_load;
	} atr_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic warm;
		logic reach;
		logic out_free;
	} atr_sts_t;

endpackage

// ----- hdl/atr_ctrl.sv -----
module atr_ctrl
	import atr_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  atr_sts_t sts,
	output atr_cmd_t cmd
);

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_RANGE = 6'b000010,
		S_UPD   = 6'b000100,
		S_ACC   = 6'b001000,
		S_DIV   = 6'b010000,
		S_DONE  = 6'b100000
	} atr_state_t;

	atr_state_t state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic div_last;

	assign div_last = (cnt_q == CNT_W'(NUM_W - 1));
	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_RANGE;
				end
			end
			S_RANGE: begin
				cmd.range = 1'b1;
				state_d   = S_UPD;
			end
			S_UPD: begin
				cmd.update = 1'b1;
				priority if (!sts.warm) begin
					state_d = S_ACC;
				end else if (sts.reach) begin
					cmd.load_sum = 1'b1;
					cnt_d        = '0;
					state_d      = S_DIV;
				end else begin
					state_d = S_DONE;
				end
			end
			S_ACC: begin
				cmd.load_acc = 1'b1;
				cnt_d        = '0;
				state_d      = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (div_last) begin
					state_d = S_DONE;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			S_DONE: begin
				// hold until the output register can take the result
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

endmodule

// ----- hdl/atr_dp.sv -----
module atr_dp
	import atr_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  atr_cmd_t            cmd,
	output atr_sts_t            sts,
	input  logic [PERIOD_W-1:0] p_eff,
	input  logic [PRICE_W-1:0]  high,
	input  logic [PRICE_W-1:0]  low,
	input  logic [PRICE_W-1:0]  close,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [PRICE_W-1:0]  true_range,
	output logic [PRICE_W-1:0]  average_range,
	output logic                average_valid
);

	// captured bar
	logic [PRICE_W-1:0] hi_q, lo_q, cl_q;

	// running state
	logic [PRICE_W-1:0]  prev_close_q;
	logic                have_prev_q;
	logic [PERIOD_W-1:0] bar_count_q;
	logic [SUM_W-1:0]    sum_q;
	logic [AVG_W-1:0]    avg_q;

	// per-bar work
	logic [PRICE_W-1:0]  tr_q;
	logic                res_valid_q;
	logic [PROD_W-1:0]   prod_q;
	logic [NUM_W-1:0]    num_q;
	logic [PERIOD_W-1:0] rem_q;

	// output register
	logic                out_valid_q;
	logic [PRICE_W-1:0]  tr_out_q;
	logic [PRICE_W-1:0]  avg_out_q;
	logic                avg_valid_q;

	// true range
	logic [PRICE_W:0]   hl_diff, hc_diff, lc_diff;
	logic [PRICE_W-1:0] hl, d1, d2, m1, tr_d;

	assign hl_diff = {1'b0, hi_q} - {1'b0, lo_q};
	assign hc_diff = {1'b0, hi_q} - {1'b0, prev_close_q};
	assign lc_diff = {1'b0, lo_q} - {1'b0, prev_close_q};

	always_comb begin
		hl   = hl_diff[PRICE_W] ? '0 : hl_diff[PRICE_W-1:0];
		d1   = hc_diff[PRICE_W] ? (prev_close_q - hi_q) : hc_diff[PRICE_W-1:0];
		d2   = lc_diff[PRICE_W] ? (prev_close_q - lo_q) : lc_diff[PRICE_W-1:0];
		m1   = (d1 > hl) ? d1 : hl;
		tr_d = have_prev_q ? ((d2 > m1) ? d2 : m1) : hl;
	end

	// warm-up bookkeeping
	logic [PERIOD_W-1:0] count_inc;
	logic [SUM_W-1:0]    sum_next;
	logic [PERIOD_W-1:0] pm1;
	logic [PROD_W-1:0]   prod_d;

	assign count_inc = bar_count_q + 1'b1;
	assign sum_next  = sum_q + SUM_W'(tr_q);
	assign pm1       = p_eff - 1'b1;
	assign prod_d    = avg_q * pm1;

	assign sts.warm     = (bar_count_q < p_eff);
	assign sts.reach    = (count_inc == p_eff);
	assign sts.out_free = !out_valid_q || out_ready;

	// restoring divider, one quotient bit per step
	logic [PERIOD_W:0]   trial, trial_sub;
	logic                q_bit;

	assign trial     = {rem_q, num_q[NUM_W-1]};
	assign trial_sub = trial - {1'b0, p_eff};
	assign q_bit     = (trial >= {1'b0, p_eff});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_close_q <= '0;
			have_prev_q  <= 1'b0;
			bar_count_q  <= '0;
			sum_q        <= '0;
			avg_q        <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cmd.range) begin
				prev_close_q <= cl_q;
				have_prev_q  <= 1'b1;
			end
			if (cmd.update) begin
				if (sts.warm) begin
					bar_count_q <= count_inc;
					sum_q       <= sum_next;
				end else begin
					bar_count_q <= p_eff;
				end
			end
			if (cmd.out_load && res_valid_q) begin
				avg_q <= num_q[AVG_W-1:0];
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			hi_q <= high;
			lo_q <= low;
			cl_q <= close;
		end
		if (cmd.range) begin
			tr_q <= tr_d;
		end
		if (cmd.update) begin
			res_valid_q <= !sts.warm || sts.reach;
			prod_q      <= prod_d;
		end
		priority if (cmd.load_sum) begin
			num_q <= NUM_W'({sum_next, FRAC_X'(0)});
			rem_q <= '0;
		end else if (cmd.load_acc) begin
			num_q <= NUM_W'(prod_q) + NUM_W'({tr_q, FRAC_X'(0)});
			rem_q <= '0;
		end else if (cmd.div_step) begin
			num_q <= {num_q[NUM_W-2:0], q_bit};
			rem_q <= q_bit ? trial_sub[PERIOD_W-1:0] : trial[PERIOD_W-1:0];
		end
		if (cmd.out_load) begin
			tr_out_q    <= tr_q;
			avg_valid_q <= res_valid_q;
			avg_out_q   <= res_valid_q ? num_q[AVG_W-1:FRAC_X] : '0;
		end
	end

	assign out_valid     = out_valid_q;
	assign true_range    = tr_out_q;
	assign average_range = avg_out_q;
	assign average_valid = avg_valid_q;

endmodule

// ----- hdl/average_true_range_unit.sv -----
// Channel  Handshake              Payload
// -------  ---------------------  ------------------------------------------
// config   psel/penable/pready    paddr, pwrite, pwdata, prdata (period)
// in       in_valid/in_ready      high, low, close (Q16.16)
// out      out_valid/out_ready    true_range, average_range, average_valid
//
// One bar at a time. A smoothed bar and the bar that completes warm-up both
// pass through the 59-step restoring divider; a warm-up bar that yields no
// average skips it. in_ready is high only when the sequencer is idle. Reset
// clears the running state and period to 14. A result waits in the output
// register; the next bar is taken meanwhile and its result holds until
// out_ready frees the register.
module average_true_range_unit
	import atr_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [ADDR_W-1:0]   paddr,
	input  logic [DATA_W-1:0]   pwdata,
	output logic [DATA_W-1:0]   prdata,
	output logic                pready,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [PRICE_W-1:0]  high,
	input  logic [PRICE_W-1:0]  low,
	input  logic [PRICE_W-1:0]  close,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [PRICE_W-1:0]  true_range,
	output logic [PRICE_W-1:0]  average_range,
	output logic                average_valid
);

	logic [PERIOD_W-1:0] period_q;
	logic [PERIOD_W-1:0] p_eff;
	logic                cfg_wr;
	atr_cmd_t            cmd;
	atr_sts_t            sts;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr == ADDR_PERIOD);
	assign prdata = (paddr == ADDR_PERIOD) ? DATA_W'(period_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= PERIOD_RESET;
		end else if (cfg_wr) begin
			period_q <= pwdata[PERIOD_W-1:0];
		end
	end

	// zero acts as one, clamp to the supported maximum
	always_comb begin
		priority if (period_q == '0) begin
			p_eff = PERIOD_W'(1);
		end else if (32'(period_q) > MAX_PERIOD) begin
			p_eff = PERIOD_W'(MAX_PERIOD);
		end else begin
			p_eff = period_q;
		end
	end

	atr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	atr_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.p_eff         (p_eff),
		.high          (high),
		.low           (low),
		.close         (close),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.true_range    (true_range),
		.average_range (average_range),
		.average_valid (average_valid)
	);

	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("in_ready still high after an input transfer");

	a_na_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !average_valid |-> average_range == '0)
		else $error("average_range nonzero while average not valid");

	a_load_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> sts.out_free)
		else $error("result loaded over an untaken output");

	a_one_cmd_load: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load_sum, cmd.load_acc, cmd.div_step}))
		else $error("conflicting divider commands");

endmodule
